// ----- rtl/wmsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wmsd_pkg: shared types and codes for the window max sample delta block
// Word layouts for both channels, command codes, register codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package wmsd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int START_W  = 6;
   localparam int INDEX_W  = 10;
   localparam int WS_REG_W = 11;
   localparam int BL_REG_W = 7;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   // request command codes
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register select, taken from paddr[2]
   localparam logic REG_WINDOW_SIZE = 1'b0;
   localparam logic REG_BLOCK_LEN   = 1'b1;

   typedef struct packed {
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] sample;
      logic [START_W-1:0]         start_offset;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  peak_index;
      logic [SAMPLE_W-1:0] peak_delta;
      logic                found;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_OFFS,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/window_max_sample_delta.sv -----
`default_nettype none
// Push word: accepted in any idle cycle, one per cycle, no result.
// Query word: N = window_size + (start > 0 ? 1 : 0) history reads, one per cycle from the
//   single read port of the history RAM; the result turns valid once the reads have drained,
//   later while an earlier result waits untaken, and the block is ready again in that cycle.
// Reset (synchronous): control registers return to their defaults and the history reads as zero.
//   Unwritten slots are masked by the write pointer and a full flag; there is no clearing pass.
// ----------------------------------------------------------------------------
// window_max_sample_delta: largest neighbour difference in a sample window
// Keeps a ring of the most recent samples in a RAM with one write and one read
// port. A query walks window_size samples from a clamped start position, one per
// cycle, through a shared subtract and compare pipeline and reports the largest
// absolute difference between neighbours together with its window index.
// ----------------------------------------------------------------------------
module window_max_sample_delta #(
   parameter int MAX_WINDOW = 1024,
   parameter int MAX_BLOCK  = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wmsd_pkg::req_type                 req_data,
   // result channel
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output wmsd_pkg::rsp_type                 rsp_data,
   // register port
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [wmsd_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire  [wmsd_pkg::CSR_W-1:0]        csr_pwdata,
   output logic [wmsd_pkg::CSR_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   // History depth covers the largest window plus the largest block.
   localparam int DEPTH  = MAX_WINDOW + MAX_BLOCK;
   localparam int AW     = $clog2(DEPTH);
   localparam int SW     = AW + 2;                 // holds sums below 4*DEPTH
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int BLK_W  = $clog2(MAX_BLOCK + 1);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
   localparam int IDX_W  = $clog2(MAX_WINDOW);
   localparam int WS_RST = (1024 > MAX_WINDOW) ? MAX_WINDOW : 1024;
   localparam int BL_RST = (64 > MAX_BLOCK) ? MAX_BLOCK : 64;

   localparam int SMP_W  = wmsd_pkg::SAMPLE_W;

   localparam int WS_REG_W_L = wmsd_pkg::WS_REG_W;
   localparam int BL_REG_W_L = wmsd_pkg::BL_REG_W;

   // Sequencer
   wmsd_pkg::state_type state_ff, state_in;

   // Ring control: write pointer and "every slot written" flag
   logic [AW-1:0]        wp_ff, wp_in;
   logic                 full_ff, full_in;

   // Registers
   logic [WIN_W-1:0]     window_size_ff, window_size_in;
   logic [BLK_W-1:0]     block_len_ff, block_len_in;

   // Query context
   logic [wmsd_pkg::START_W-1:0] start_ff, start_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Read stage
   logic                 s1_vld_ff, s1_vld_in;
   logic [SMP_W-1:0]     rd_data_ff;
   logic                 rd_ok_ff;
   logic signed [SMP_W-1:0] prev_ff, prev_in;
   logic                 have_prev_ff, have_prev_in;

   // Difference stage
   logic                 s2_vld_ff, s2_vld_in;
   logic [SMP_W-1:0]     d_ff, d_in;

   // Running best
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SMP_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 found_ff, found_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   wmsd_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // History RAM
   logic [SMP_W-1:0]     hist_mem [DEPTH];

   // Combinational helpers
   logic                 cfg_wr;
   logic                 push;
   logic                 query;
   logic [WS_REG_W_L-1:0] ws_wr;
   logic [BL_REG_W_L-1:0] bl_wr;
   logic signed [SMP_W-1:0] cur;
   logic [SMP_W:0]       cur_x, prev_x, diff_x;
   logic                 cur_ge;
   logic [SW-1:0]        base_sum, offs_sum, len_sum;
   logic [wmsd_pkg::START_W-1:0] first_k;
   logic                 start_nz;
   logic [AW-1:0]        addr_next;

   assign csr_pready = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Register read-back
   always_comb begin
      unique case (csr_paddr[2])
         wmsd_pkg::REG_WINDOW_SIZE: csr_prdata = wmsd_pkg::CSR_W'(window_size_ff);
         wmsd_pkg::REG_BLOCK_LEN:   csr_prdata = wmsd_pkg::CSR_W'(block_len_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Next state and datapath
   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      full_in        = full_ff;
      window_size_in = window_size_ff;
      block_len_in   = block_len_ff;
      start_in       = start_ff;
      addr_in        = addr_ff;
      cnt_in         = cnt_ff;
      s1_vld_in      = 1'b0;
      prev_in        = prev_ff;
      have_prev_in   = have_prev_ff;
      s2_vld_in      = 1'b0;
      d_in           = d_ff;
      idx_in         = idx_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      req_ready = (state_ff == wmsd_pkg::ST_IDLE);
      cfg_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
      push      = req_valid && req_ready && (req_data.cmd == wmsd_pkg::CMD_PUSH);
      query     = req_valid && req_ready && (req_data.cmd == wmsd_pkg::CMD_QUERY);

      ws_wr = csr_pwdata[WS_REG_W_L-1:0];
      bl_wr = csr_pwdata[BL_REG_W_L-1:0];

      // Slots never written since the last clear read as silence.
      cur    = rd_ok_ff ? $signed(rd_data_ff) : '0;
      cur_x  = {cur[SMP_W-1], cur};
      prev_x = {prev_ff[SMP_W-1], prev_ff};
      cur_ge = (cur >= prev_ff);
      diff_x = cur_ge ? (cur_x - prev_x) : (prev_x - cur_x);

      // Physical slot of the oldest sample in the active history
      len_sum  = SW'(window_size_ff) + SW'(block_len_ff);
      base_sum = SW'(wp_ff) + SW'(DEPTH) - len_sum;
      if (base_sum >= SW'(DEPTH)) begin
         base_sum = base_sum - SW'(DEPTH);
      end

      start_nz = (start_ff != '0);
      first_k  = start_nz ? (start_ff - 1'b1) : '0;
      offs_sum = SW'(addr_ff) + SW'(first_k);
      if (offs_sum >= SW'(DEPTH)) begin
         offs_sum = offs_sum - SW'(DEPTH);
      end

      addr_next = (addr_ff == AW'(DEPTH - 1)) ? '0 : (addr_ff + 1'b1);

      // Register writes; any write also empties the history
      if (cfg_wr) begin
         unique case (csr_paddr[2])
            wmsd_pkg::REG_WINDOW_SIZE: begin
               if (ws_wr < WS_REG_W_L'(2)) begin
                  window_size_in = WIN_W'(2);
               end else if (ws_wr > MAX_WINDOW) begin
                  window_size_in = WIN_W'(MAX_WINDOW);
               end else begin
                  window_size_in = WIN_W'(ws_wr);
               end
            end
            wmsd_pkg::REG_BLOCK_LEN: begin
               if (bl_wr < BL_REG_W_L'(1)) begin
                  block_len_in = BLK_W'(1);
               end else if (bl_wr > MAX_BLOCK) begin
                  block_len_in = BLK_W'(MAX_BLOCK);
               end else begin
                  block_len_in = BLK_W'(bl_wr);
               end
            end
            default: begin
            end
         endcase
         wp_in   = '0;
         full_in = 1'b0;
      end

      // Advance the ring on a push
      if (push) begin
         if (wp_ff == AW'(DEPTH - 1)) begin
            wp_in   = '0;
            full_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end

      // Read stage: hold the previous sample, form the difference
      if (s1_vld_ff) begin
         prev_in      = cur;
         have_prev_in = 1'b1;
         if (have_prev_ff) begin
            d_in      = diff_x[SMP_W-1:0];
            s2_vld_in = 1'b1;
         end
      end

      // Compare stage: strictly greater keeps the earliest index on ties
      if (s2_vld_ff) begin
         if (!found_ff || (d_ff > best_ff)) begin
            best_in     = d_ff;
            best_idx_in = idx_ff;
            found_in    = 1'b1;
         end
         idx_in = idx_ff + 1'b1;
      end

      // Drop the output word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         wmsd_pkg::ST_IDLE: begin
            if (query) begin
               if (req_data.start_offset >= block_len_ff) begin
                  start_in = wmsd_pkg::START_W'(block_len_ff - 1'b1);
               end else begin
                  start_in = req_data.start_offset;
               end
               state_in = wmsd_pkg::ST_BASE;
            end
         end
         wmsd_pkg::ST_BASE: begin
            addr_in      = AW'(base_sum);
            have_prev_in = 1'b0;
            found_in     = 1'b0;
            best_in      = '0;
            best_idx_in  = '0;
            state_in     = wmsd_pkg::ST_OFFS;
         end
         wmsd_pkg::ST_OFFS: begin
            addr_in  = AW'(offs_sum);
            cnt_in   = CNT_W'(window_size_ff) + CNT_W'(start_nz);
            idx_in   = start_nz ? '0 : IDX_W'(1);
            state_in = wmsd_pkg::ST_SCAN;
         end
         wmsd_pkg::ST_SCAN: begin
            s1_vld_in = 1'b1;
            addr_in   = addr_next;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = wmsd_pkg::ST_DRAIN;
            end
         end
         wmsd_pkg::ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = wmsd_pkg::ST_DONE;
            end
         end
         wmsd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.peak_index = wmsd_pkg::INDEX_W'(best_idx_ff);
               rsp_data_in.peak_delta = best_ff;
               rsp_data_in.found      = found_ff;
               state_in               = wmsd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wmsd_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wmsd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff          <= '0;
         full_ff        <= 1'b0;
         window_size_ff <= WIN_W'(WS_RST);
         block_len_ff   <= BLK_W'(BL_RST);
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         have_prev_ff   <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         wp_ff          <= wp_in;
         full_ff        <= full_in;
         window_size_ff <= window_size_in;
         block_len_ff   <= block_len_in;
         s1_vld_ff      <= s1_vld_in;
         s2_vld_ff      <= s2_vld_in;
         have_prev_ff   <= have_prev_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      prev_ff     <= prev_in;
      d_ff        <= d_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_data_ff <= rsp_data_in;
      rd_ok_ff    <= full_ff || (addr_ff < wp_ff);
   end

   // History RAM: one write port for pushes, one registered read port
   always_ff @(posedge clock) begin
      if (push) begin
         hist_mem[wp_ff] <= req_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[addr_ff];
   end

`ifndef SYNTHESIS
   // The scan never runs with an exhausted read count.
   a_scan_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wmsd_pkg::ST_SCAN) |-> (cnt_ff != '0))
      else $error("scan with zero read count");

   // Every window holds at least one pair, so a result always has found set.
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.found)
      else $error("result without any evaluated pair");

   // No words are taken while a query walks the history.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff) |-> !req_ready)
      else $error("request accepted during a scan");

   // The winning index lies inside the window.
   a_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wmsd_pkg::ST_DONE) |-> (WIN_W'(best_idx_ff) < window_size_ff))
      else $error("peak index outside window");

   // A result appears only as the sequencer leaves its final state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == wmsd_pkg::ST_DONE))
      else $error("result raised outside completion");
`endif

endmodule
`default_nettype wire
